>>> sv/rwl_pkg.sv
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared types, codes and default sizes for the fair FIFO readers-writers
// lock arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package rwl_pkg;

  // Default sizes
  localparam int QUEUE_DEPTH = 16;
  localparam int REQUESTERS  = 64;
  localparam int MAX_RESULTS = 16;

  // Lock commands
  localparam logic [1:0] CMD_START_READ  = 2'd0;
  localparam logic [1:0] CMD_DONE_READ   = 2'd1;
  localparam logic [1:0] CMD_START_WRITE = 2'd2;
  localparam logic [1:0] CMD_DONE_WRITE  = 2'd3;

  // Result events
  localparam logic [2:0] EV_QUEUED   = 3'd0;
  localparam logic [2:0] EV_GRANTED  = 3'd1;
  localparam logic [2:0] EV_RELEASED = 3'd2;
  localparam logic [2:0] EV_FULL     = 3'd3;
  localparam logic [2:0] EV_BADREL   = 3'd4;

  // Lock modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] requester_id;
  } req_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [5:0] target_id;
    logic       is_write;
    logic [6:0] readers_active;
    logic       last;
  } rsp_t;

  // One waiting request in the queue
  typedef struct packed {
    logic       is_write;
    logic [5:0] id;
  } entry_t;

  // Queue control from the sequencer
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t wdata;
  } fifo_ctl_t;

  // Result offered by the sequencer to the output register
  typedef struct packed {
    logic valid;
    rsp_t data;
  } res_t;

endpackage

`default_nettype wire

>>> sv/rwl_wait_fifo.sv
// ----------------------------------------------------------------------------
// rwl_wait_fifo
// Circular queue of waiting requests with a registered head read.
// ----------------------------------------------------------------------------
`default_nettype none

module rwl_wait_fifo #(
  parameter int QUEUE_DEPTH = rwl_pkg::QUEUE_DEPTH,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rwl_pkg::fifo_ctl_t ctl,
  output logic [CW-1:0]           count,
  output rwl_pkg::entry_t         head_entry
);

  rwl_pkg::entry_t mem [QUEUE_DEPTH];
  logic [AW-1:0]   head;
  logic [AW-1:0]   tail;

  // Storage: write at the tail, read the head every cycle
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= ctl.wdata;
    end
    head_entry <= mem[head];
  end

  // Pointers wrap at the queue depth
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctl.push) begin
        tail  <= (tail == AW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end else if (ctl.pop) begin
        head  <= (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/rwl_ctrl.sv
// ----------------------------------------------------------------------------
// rwl_ctrl
// Lock state and sequencer: evaluates one command, then admits queued
// requests one at a time, holding each result until the next is known.
// ----------------------------------------------------------------------------
`default_nettype none

module rwl_ctrl #(
  parameter int QUEUE_DEPTH = rwl_pkg::QUEUE_DEPTH,
  parameter int REQUESTERS  = rwl_pkg::REQUESTERS,
  localparam int CW  = $clog2(QUEUE_DEPTH + 1),
  localparam int RCW = $clog2(REQUESTERS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_take,
  input  wire rwl_pkg::req_t      req,
  input  wire logic [CW-1:0]      q_count,
  input  wire rwl_pkg::entry_t    head_entry,
  input  wire logic               slot_free,
  output logic                    busy,
  output rwl_pkg::fifo_ctl_t      fctl,
  output rwl_pkg::res_t           res
);

  localparam int NW = $clog2(rwl_pkg::MAX_RESULTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMD   = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_ADMIT = 2'd3;

  logic [1:0]     state, state_next;
  logic [1:0]     mode, mode_next;
  logic [RCW-1:0] rc, rc_next;
  logic [NW-1:0]  n, n_next;
  rwl_pkg::req_t  cur, cur_next;
  rwl_pkg::rsp_t  pend, pend_next;

  logic q_full;
  logic q_empty;
  logic rc_max;
  logic grant_ok;

  assign q_full  = (q_count == CW'(QUEUE_DEPTH));
  assign q_empty = (q_count == '0);
  assign rc_max  = (rc == RCW'(REQUESTERS));
  assign busy    = (state != ST_IDLE);

  // Can the queue head be admitted now?
  always_comb begin
    grant_ok = 1'b0;
    if (n != NW'(rwl_pkg::MAX_RESULTS) && !q_empty) begin
      if (head_entry.is_write) begin
        grant_ok = (mode == rwl_pkg::MODE_IDLE);
      end else begin
        grant_ok = (mode != rwl_pkg::MODE_WRITE) && !rc_max;
      end
    end
  end

  always_comb begin
    state_next = state;
    mode_next  = mode;
    rc_next    = rc;
    n_next     = n;
    cur_next   = cur;
    pend_next  = pend;
    fctl       = '0;
    res        = '0;
    res.data   = pend;

    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          cur_next   = req;
          state_next = ST_CMD;
        end
      end

      ST_CMD: begin
        pend_next.target_id = cur.requester_id;
        pend_next.last      = 1'b0;
        unique case (cur.cmd)
          rwl_pkg::CMD_START_READ: begin
            pend_next.is_write = 1'b0;
            if (mode == rwl_pkg::MODE_WRITE || !q_empty || rc_max) begin
              pend_next.event_res = q_full ? rwl_pkg::EV_FULL : rwl_pkg::EV_QUEUED;
              fctl.push           = !q_full;
            end else begin
              rc_next             = rc + 1'b1;
              mode_next           = rwl_pkg::MODE_READ;
              pend_next.event_res = rwl_pkg::EV_GRANTED;
            end
          end
          rwl_pkg::CMD_DONE_READ: begin
            pend_next.is_write = 1'b0;
            if (mode != rwl_pkg::MODE_READ || rc == '0) begin
              pend_next.event_res = rwl_pkg::EV_BADREL;
            end else begin
              rc_next = rc - 1'b1;
              if (rc == RCW'(1)) begin
                mode_next = rwl_pkg::MODE_IDLE;
              end
              pend_next.event_res = rwl_pkg::EV_RELEASED;
            end
          end
          rwl_pkg::CMD_START_WRITE: begin
            pend_next.is_write = 1'b1;
            if (mode != rwl_pkg::MODE_IDLE || !q_empty) begin
              pend_next.event_res = q_full ? rwl_pkg::EV_FULL : rwl_pkg::EV_QUEUED;
              fctl.push           = !q_full;
            end else begin
              mode_next           = rwl_pkg::MODE_WRITE;
              pend_next.event_res = rwl_pkg::EV_GRANTED;
            end
          end
          rwl_pkg::CMD_DONE_WRITE: begin
            pend_next.is_write = 1'b1;
            if (mode != rwl_pkg::MODE_WRITE) begin
              pend_next.event_res = rwl_pkg::EV_BADREL;
            end else begin
              mode_next           = rwl_pkg::MODE_IDLE;
              pend_next.event_res = rwl_pkg::EV_RELEASED;
            end
          end
          default: begin
          end
        endcase
        pend_next.readers_active = 7'(rc_next);
        fctl.wdata.is_write      = pend_next.is_write;
        fctl.wdata.id            = cur.requester_id;
        n_next                   = NW'(1);
        state_next               = ST_WAIT;
      end

      // Let the head read settle after a push or pop
      ST_WAIT: begin
        state_next = ST_ADMIT;
      end

      ST_ADMIT: begin
        if (slot_free) begin
          res.valid = 1'b1;
          if (grant_ok) begin
            res.data.last       = 1'b0;
            fctl.pop            = 1'b1;
            pend_next.event_res = rwl_pkg::EV_GRANTED;
            pend_next.target_id = head_entry.id;
            pend_next.is_write  = head_entry.is_write;
            pend_next.last      = 1'b0;
            if (head_entry.is_write) begin
              mode_next = rwl_pkg::MODE_WRITE;
            end else begin
              mode_next = rwl_pkg::MODE_READ;
              rc_next   = rc + 1'b1;
            end
            pend_next.readers_active = 7'(rc_next);
            n_next     = n + 1'b1;
            state_next = ST_WAIT;
          end else begin
            res.data.last = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mode  <= rwl_pkg::MODE_IDLE;
      rc    <= '0;
      n     <= '0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      rc    <= rc_next;
      n     <= n_next;
    end
  end

  always_ff @(posedge clk) begin
    cur  <= cur_next;
    pend <= pend_next;
  end

endmodule

`default_nettype wire

>>> sv/fifo_fair_rw_lock_arbiter_top.sv
// ----------------------------------------------------------------------------
// fifo_fair_rw_lock_arbiter_top
// Fair FIFO readers-writers lock arbiter with a request queue.
// ----------------------------------------------------------------------------
// Each accepted request carries one lock command (start read, done read,
// start write, done write) and a requester id. The block answers with one
// result for the command itself, then one grant result for each queued
// request that the new lock state admits, in queue order; the final result
// of a request has last set. Readers share the lock, writers own it alone,
// and nobody overtakes a waiting request. A request that must wait while the
// queue is full, or a release that does not match the lock mode, gives an
// error result and leaves the state alone. One request is worked on at a
// time: a request with a single result goes through accept, evaluate, head
// read and close, and each admitted grant adds another head read and admit
// step, due to the registered read port of the wait queue, which must settle
// after every push or pop before the head can be judged. At most MAX_RESULTS
// results come from one request; readers still waiting past that point are
// admitted after a later request. The last result sits in an output register
// so the next request can be accepted while it waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_fair_rw_lock_arbiter_top #(
  parameter int QUEUE_DEPTH = rwl_pkg::QUEUE_DEPTH,
  parameter int REQUESTERS  = rwl_pkg::REQUESTERS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire rwl_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output rwl_pkg::rsp_t      rsp
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic               busy;
  logic               req_take;
  logic               slot_free;
  logic [CW-1:0]      q_count;
  rwl_pkg::entry_t    head_entry;
  rwl_pkg::fifo_ctl_t fctl;
  rwl_pkg::res_t      res;

  // Take a new request only while the sequencer is idle
  assign req_stall = busy;
  assign req_take  = req_valid && !busy;

  // Output slot is free when empty or being drained this cycle
  assign slot_free = !rsp_valid || !rsp_stall;

  rwl_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .REQUESTERS  (REQUESTERS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_take   (req_take),
    .req        (req),
    .q_count    (q_count),
    .head_entry (head_entry),
    .slot_free  (slot_free),
    .busy       (busy),
    .fctl       (fctl),
    .res        (res)
  );

  rwl_wait_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .ctl        (fctl),
    .count      (q_count),
    .head_entry (head_entry)
  );

  // Output register: load a result whenever the slot is free, hold on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (slot_free) begin
      rsp_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res.valid) begin
      rsp <= res.data;
    end
  end

endmodule

`default_nettype wire

>>> sv/rwl_checker.sv
// ----------------------------------------------------------------------------
// rwl_checker
// Port-level checks for the lock arbiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rwl_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire rwl_pkg::rsp_t rsp
);

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // Work on one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while previous one in progress");

  // A writer is only ever granted with no active reader
  a_write_grant_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.event_res == rwl_pkg::EV_GRANTED && rsp.is_write
      |-> rsp.readers_active == '0)
    else $error("write granted with readers active");

  // A write release leaves no reader behind
  a_write_release_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && rsp.event_res == rwl_pkg::EV_RELEASED && rsp.is_write
      |-> rsp.readers_active == '0)
    else $error("write released with readers active");

endmodule

bind fifo_fair_rw_lock_arbiter_top rwl_checker u_rwl_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

>>> verif/fifo_fair_rw_lock_arbiter_top_test.sv
// ----------------------------------------------------------------------------
// fifo_fair_rw_lock_arbiter_top_test
// Self-checking bench for the fair FIFO readers-writers lock arbiter.
// ----------------------------------------------------------------------------
// Lock commands go in over the request channel and the event results come
// back on the response channel. A short directed table walks bad releases on
// an idle lock, queuing behind a reader, a full wait queue and a reader chain
// that hits the per-request result cap. Random traffic follows: commands
// weighted by the lock state, writer backlogs, a reader flood past the reader
// limit, and pure noise. An in-bench lock model predicts every result, and
// each response is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module fifo_fair_rw_lock_arbiter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rwl_pkg::*;

  // Directed table row: command, requester, and a hand-written first result
  // where the outcome is obvious (typed set). Other rows use the lock model.
  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] id;
    logic       typed;
    logic [2:0] ev;
    logic       wr;
    logic [6:0] readers;
  } dir_row_t;

  logic  clk;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  // Lock model state
  logic [1:0] lk_mode = MODE_IDLE;
  int         lk_readers = 0;
  entry_t     lk_fifo [QUEUE_DEPTH];
  int         lk_head = 0;
  int         lk_tail = 0;
  int         lk_fill = 0;

  rsp_t step_events [$];     // events caused by the request being modeled
  rsp_t pending_events [$];  // predicted events not yet seen on rsp

  int errors = 0;
  int sent = 0;
  int tx_idle = 15;          // sender idle chance, percent
  int rx_idle = 78;          // receiver stall chance, percent
  int hold_cycles = 0;
  bit hold_go = 1'b0;

  dir_row_t plan [0:24] = '{
    '{CMD_DONE_READ,   6'd0,  1'b1, EV_BADREL,  1'b0, 7'd0},
    '{CMD_DONE_WRITE,  6'd63, 1'b1, EV_BADREL,  1'b1, 7'd0},
    '{CMD_START_READ,  6'd0,  1'b1, EV_GRANTED, 1'b0, 7'd1},
    '{CMD_START_WRITE, 6'd63, 1'b1, EV_QUEUED,  1'b1, 7'd1},
    '{CMD_START_READ,  6'd5,  1'b1, EV_QUEUED,  1'b0, 7'd1},
    '{CMD_DONE_READ,   6'd0,  1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_DONE_READ,   6'd42, 1'b1, EV_BADREL,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd10, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd11, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd12, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd13, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd14, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd15, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd16, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd17, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd18, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd19, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd20, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd21, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd22, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd23, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd24, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_READ,  6'd33, 1'b1, EV_FULL,    1'b0, 7'd0},
    '{CMD_DONE_WRITE,  6'd21, 1'b0, EV_QUEUED,  1'b0, 7'd0},
    '{CMD_START_WRITE, 6'd62, 1'b0, EV_QUEUED,  1'b0, 7'd0}
  };

  fifo_fair_rw_lock_arbiter_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #6_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Lock model
  // --------------------------------------------------------------------------

  // Record one event with the reader count as it stands now.
  function void note_event(logic [2:0] ev, logic [5:0] id, logic wr);
    rsp_t e;
    e.event_res      = ev;
    e.target_id      = id;
    e.is_write       = wr;
    e.readers_active = 7'(lk_readers);
    e.last           = 1'b0;
    step_events.push_back(e);
  endfunction

  // Queue the request, or reject it when the wait queue is full.
  function void wait_or_reject(logic [5:0] id, logic wr);
    if (lk_fill >= QUEUE_DEPTH) begin
      note_event(EV_FULL, id, wr);
    end else begin
      lk_fifo[lk_tail] = '{is_write: wr, id: id};
      lk_tail = (lk_tail + 1) % QUEUE_DEPTH;
      lk_fill++;
      note_event(EV_QUEUED, id, wr);
    end
  endfunction

  // Apply one lock command and fill step_events with what it causes.
  function void predict_lock_events(req_t r);
    entry_t head;
    rsp_t   tail_ev;
    step_events.delete();
    case (r.cmd)
      CMD_START_READ: begin
        if (lk_mode == MODE_WRITE || lk_fill > 0 || lk_readers >= REQUESTERS) begin
          wait_or_reject(r.requester_id, 1'b0);
        end else begin
          lk_readers++;
          lk_mode = MODE_READ;
          note_event(EV_GRANTED, r.requester_id, 1'b0);
        end
      end
      CMD_DONE_READ: begin
        if (lk_mode != MODE_READ || lk_readers == 0) begin
          note_event(EV_BADREL, r.requester_id, 1'b0);
        end else begin
          lk_readers--;
          if (lk_readers == 0) lk_mode = MODE_IDLE;
          note_event(EV_RELEASED, r.requester_id, 1'b0);
        end
      end
      CMD_START_WRITE: begin
        if (lk_mode != MODE_IDLE || lk_fill > 0) begin
          wait_or_reject(r.requester_id, 1'b1);
        end else begin
          lk_mode = MODE_WRITE;
          note_event(EV_GRANTED, r.requester_id, 1'b1);
        end
      end
      default: begin
        if (lk_mode != MODE_WRITE) begin
          note_event(EV_BADREL, r.requester_id, 1'b1);
        end else begin
          lk_mode = MODE_IDLE;
          note_event(EV_RELEASED, r.requester_id, 1'b1);
        end
      end
    endcase
    // Admit waiting requests from the head, capped per request.
    while (step_events.size() < MAX_RESULTS && lk_fill > 0) begin
      head = lk_fifo[lk_head];
      if (head.is_write) begin
        if (lk_mode != MODE_IDLE) break;
        lk_head = (lk_head + 1) % QUEUE_DEPTH;
        lk_fill--;
        lk_mode = MODE_WRITE;
        note_event(EV_GRANTED, head.id, 1'b1);
        break;
      end
      if (lk_mode == MODE_WRITE || lk_readers >= REQUESTERS) break;
      lk_head = (lk_head + 1) % QUEUE_DEPTH;
      lk_fill--;
      lk_mode = MODE_READ;
      lk_readers++;
      note_event(EV_GRANTED, head.id, 1'b0);
    end
    tail_ev = step_events.pop_back();
    tail_ev.last = 1'b1;
    step_events.push_back(tail_ev);
  endfunction

  // Pick a plausible next command for the current lock state.
  function req_t pick_lock_cmd();
    req_t r;
    int   roll;
    roll = $urandom_range(99);
    r.requester_id = 6'($urandom_range(63));
    case (lk_mode)
      MODE_WRITE: r.cmd = (roll < 45) ? CMD_DONE_WRITE :
                          (roll < 80) ? CMD_START_READ : CMD_START_WRITE;
      MODE_READ:  r.cmd = (roll < 50) ? CMD_DONE_READ :
                          (roll < 80) ? CMD_START_READ : CMD_START_WRITE;
      default:    r.cmd = (roll < 60) ? CMD_START_READ : CMD_START_WRITE;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request, starting at a falling edge. Optionally idle first.
  // On acceptance, predict its events, or use the typed result instead.
  task automatic offer(input req_t r, input bit typed, input rsp_t want);
    int gap;
    if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
      gap = $urandom_range(6, 1);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    // Hold the request until the block takes it.
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    sent++;
    predict_lock_events(r);
    if (typed) begin
      pending_events.push_back(want);
    end else begin
      foreach (step_events[i]) pending_events.push_back(step_events[i]);
    end
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted event has come back.
  task automatic drain_results();
    req_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mix of random sequences: state-weighted runs, writer backlogs, noise.
  task automatic run_mix(input int count);
    int   stop;
    int   kind;
    req_t r;
    stop = sent + count;
    while (sent < stop) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        // Noise: any command from anyone, bad releases included.
        repeat ($urandom_range(3, 1)) begin
          r = req_t'(8'($urandom_range(255)));
          offer(r, 1'b0, '0);
        end
      end else if (kind <= 2) begin
        // Writer backlog: a writer, a pile of waiters, then its release.
        r.cmd = CMD_START_WRITE;
        r.requester_id = 6'($urandom_range(63));
        offer(r, 1'b0, '0);
        repeat ($urandom_range(18, 1)) begin
          r.cmd = ($urandom_range(99) < 80) ? CMD_START_READ : CMD_START_WRITE;
          r.requester_id = 6'($urandom_range(63));
          offer(r, 1'b0, '0);
        end
        r.cmd = CMD_DONE_WRITE;
        r.requester_id = 6'($urandom_range(63));
        offer(r, 1'b0, '0);
      end else begin
        repeat ($urandom_range(12, 4)) offer(pick_lock_cmd(), 1'b0, '0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Response side
  // --------------------------------------------------------------------------

  // Stall at random, or hold off for a counted stretch when asked.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_left = hold_cycles;
        hold_go   = 1'b0;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= (rx_idle > 0) && ($urandom_range(99) < rx_idle);
      end
    end
  end

  function void check_field(string name, logic [6:0] want, logic [6:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Compare every taken response with the oldest prediction.
  initial begin
    rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
        if (pending_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected response: expected none, got %h", $time, rsp);
        end else begin
          want = pending_events.pop_front();
          check_field("event_res", 7'(want.event_res), 7'(rsp.event_res));
          check_field("target_id", 7'(want.target_id), 7'(rsp.target_id));
          check_field("is_write", 7'(want.is_write), 7'(rsp.is_write));
          check_field("readers_active", want.readers_active, rsp.readers_active);
          check_field("last", 7'(want.last), 7'(rsp.last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rsp_t want;
    req_t r;
    // Hold reset, then release it on a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table: sender idles lightly, receiver stalls heavily.
    foreach (plan[i]) begin
      r.cmd              = plan[i].cmd;
      r.requester_id     = plan[i].id;
      want.event_res      = plan[i].ev;
      want.target_id      = plan[i].id;
      want.is_write       = plan[i].wr;
      want.readers_active = plan[i].readers;
      want.last           = 1'b1;
      offer(r, plan[i].typed, want);
    end

    run_mix(160);

    // Pause the sender until the block has answered everything.
    drain_results();

    // Swap the idle pattern: slow sender, fast receiver.
    tx_idle = 78;
    rx_idle = 15;
    run_mix(150);

    // No idling from here on. Hold the receiver off for a long stretch while
    // requests keep coming, so the block backs up and stalls its input.
    tx_idle     = 0;
    rx_idle     = 0;
    hold_cycles = 300;
    hold_go     = 1'b1;

    // Release whatever holds the lock, then flood with readers past the
    // reader limit so the extras queue.
    while (lk_mode != MODE_IDLE) begin
      r.cmd = (lk_mode == MODE_WRITE) ? CMD_DONE_WRITE : CMD_DONE_READ;
      r.requester_id = 6'($urandom_range(63));
      offer(r, 1'b0, '0);
    end
    repeat (REQUESTERS + QUEUE_DEPTH / 2) begin
      r.cmd = CMD_START_READ;
      r.requester_id = 6'($urandom_range(63));
      offer(r, 1'b0, '0);
    end
    run_mix(80);

    // Wait for the last events, then give a stray result time to show up.
    drain_results();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/rwl_pkg.sv
sv/rwl_wait_fifo.sv
sv/rwl_ctrl.sv
sv/fifo_fair_rw_lock_arbiter_top.sv
sv/rwl_checker.sv
verif/fifo_fair_rw_lock_arbiter_top_test.sv
